>>> rtl/core/qbpg_pkg.sv
// Package for the quadratic B-spline point generator.
// Field widths, command codes and register indexes shared by every file but qbpg_ram.
package qbpg_pkg;

  localparam int unsigned MAX_KNOTS_DEF = 64;

  localparam int unsigned OP_W    = 2;
  localparam int unsigned IDX_W   = 6;
  localparam int unsigned KNOT_W  = 32;
  localparam int unsigned PT_W    = 16;
  localparam int unsigned CRV_W   = 24;
  localparam int unsigned DENS_W  = 6;
  localparam int unsigned KCNT_W  = 7;
  localparam int unsigned CFG_IDX_W = 1;
  localparam int unsigned CFG_DAT_W = 7;

  // command codes of the input word
  localparam logic [OP_W-1:0] CMD_LOAD_KNOT  = 2'd0;
  localparam logic [OP_W-1:0] CMD_LOAD_POINT = 2'd1;
  localparam logic [OP_W-1:0] CMD_GENERATE   = 2'd2;

  // configuration register indexes
  localparam logic [CFG_IDX_W-1:0] REG_DENSITY    = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_KNOT_COUNT = 1'd1;

  localparam logic [DENS_W-1:0] DENSITY_RST    = 6'd5;
  localparam logic [KCNT_W-1:0] KNOT_COUNT_RST = 7'd36;

endpackage

>>> rtl/core/qbpg_if.sv
// Handshake channels of the point generator: command words in, points out.
// Depends on qbpg_pkg for field widths.
interface qbpg_in_if import qbpg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic [OP_W-1:0]          op;
  logic [IDX_W-1:0]         index;
  logic [KNOT_W-1:0]        knot_value;
  logic signed [PT_W-1:0]   point_x;
  logic signed [PT_W-1:0]   point_y;

  modport source (output valid, op, index, knot_value, point_x, point_y, input ready);
  modport sink   (input valid, op, index, knot_value, point_x, point_y, output ready);
endinterface

interface qbpg_out_if import qbpg_pkg::*; ();
  logic                     valid;
  logic                     ready;
  logic signed [CRV_W-1:0]  curve_x;
  logic signed [CRV_W-1:0]  curve_y;
  logic                     last;

  modport source (output valid, curve_x, curve_y, last, input ready);
  modport sink   (input valid, curve_x, curve_y, last, output ready);
endinterface

>>> rtl/core/quadratic_bspline_point_generator_unit.sv
// Top level of the quadratic B-spline point generator.
// Depends on qbpg_pkg, qbpg_if (channels) and qbpg_ram (knot and point stores).
//
// Usage:
//   in_i carries command words: load knot, load control point, or generate
//   one knot interval. Loads produce nothing and leave the block idle.
//   A generate word emits density+1 points on out_o (density 0 counts as 1),
//   the final one flagged by last; empty or out-of-range intervals emit none.
//   The configuration port (cfg_we_i, cfg_idx_i, cfg_data_i) sets density
//   and knot count; write it only while the block is idle.
// Sequence:
//   A generate word first reads the stores and checks the interval, then
//   per point makes seven passes through one shared shift-add multiplier and
//   restoring divider (setup, multiply, divide and finish states; a zero-span
//   blend ends in its setup state) and hands the point to the output register.
//   in_i.ready is high only while idle, so one word is worked on at a time.
// Reset: the sequencer returns idle, the output register empties and the
//   registers take density 5 and knot count 36; store contents are undefined
//   until written.
// Stalls: a point waits in the output register; the sequencer holds the
//   next finished point until the register is free.
module quadratic_bspline_point_generator_unit import qbpg_pkg::*; #(
  parameter int unsigned MaxKnots = MAX_KNOTS_DEF
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  qbpg_in_if.sink               in_i,
  qbpg_out_if.source            out_o,
  input  logic                  cfg_we_i,
  input  logic [CFG_IDX_W-1:0]  cfg_idx_i,
  input  logic [CFG_DAT_W-1:0]  cfg_data_i
);

  localparam int unsigned AW = $clog2(MaxKnots);

  // sequencer states
  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_READ  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SETUP = 3'd3;
  localparam logic [2:0] S_MUL   = 3'd4;
  localparam logic [2:0] S_DIV   = 3'd5;
  localparam logic [2:0] S_FIN   = 3'd6;
  localparam logic [2:0] S_EMIT  = 3'd7;

  // per-point operations
  localparam logic [2:0] OP_U   = 3'd0;
  localparam logic [2:0] OP_CX2 = 3'd1;
  localparam logic [2:0] OP_CY2 = 3'd2;
  localparam logic [2:0] OP_CX1 = 3'd3;
  localparam logic [2:0] OP_CY1 = 3'd4;
  localparam logic [2:0] OP_PX  = 3'd5;
  localparam logic [2:0] OP_PY  = 3'd6;

  logic [2:0] state_q, state_d;

  // configuration
  logic [DENS_W-1:0] dens_cfg_q;
  logic [KCNT_W-1:0] kcnt_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dens_cfg_q <= DENSITY_RST;
      kcnt_q     <= KNOT_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_DENSITY:    dens_cfg_q <= cfg_data_i[DENS_W-1:0];
        REG_KNOT_COUNT: kcnt_q     <= cfg_data_i[KCNT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [DENS_W-1:0] dens;
  assign dens = (dens_cfg_q == '0) ? DENS_W'(1) : dens_cfg_q;

  // command decode
  logic in_acc;
  logic idx_ok;
  logic [10:0] eff_cnt;
  logic gen_ok;
  assign in_i.ready = (state_q == S_IDLE);
  assign in_acc     = in_i.valid && in_i.ready;
  assign idx_ok     = (11'(in_i.index) < 11'(MaxKnots));
  assign eff_cnt    = (11'(kcnt_q) < 11'(MaxKnots)) ? 11'(kcnt_q) : 11'(MaxKnots);
  assign gen_ok     = (in_i.index != '0) && ((11'(in_i.index) + 11'd2) < eff_cnt);

  // stores
  logic [IDX_W-1:0] idx_q;
  logic [2:0]       step_q;
  logic [6:0]       rd_sum;
  logic [AW-1:0]    rd_addr;
  logic [31:0]      knot_rd, pt_rd;

  assign rd_sum  = 7'(idx_q) + 7'(step_q) - 7'd1;
  assign rd_addr = AW'(rd_sum);

  qbpg_ram #(.Width(KNOT_W), .Depth(MaxKnots)) u_knot_ram (
    .clk_i,
    .we_i    (in_acc && in_i.op == CMD_LOAD_KNOT && idx_ok),
    .waddr_i (AW'(in_i.index)),
    .wdata_i (in_i.knot_value),
    .raddr_i (rd_addr),
    .rdata_o (knot_rd)
  );

  qbpg_ram #(.Width(2*PT_W), .Depth(MaxKnots)) u_point_ram (
    .clk_i,
    .we_i    (in_acc && in_i.op == CMD_LOAD_POINT && idx_ok),
    .waddr_i (AW'(in_i.index)),
    .wdata_i ({in_i.point_y, in_i.point_x}),
    .raddr_i (rd_addr),
    .rdata_o (pt_rd)
  );

  // fetched operands: knots i-1..i+2, points i-1..i+1
  logic [KNOT_W-1:0] kn_q [4];
  logic [31:0]       pt_q [3];
  logic [KNOT_W-1:0] span_q, u_q;
  logic [DENS_W-1:0] s_q;
  logic [2:0]        op_q;
  logic signed [CRV_W-1:0] cx2_q, cy2_q, cx1_q, cy1_q, px_q, py_q;

  // shared multiply-divide unit registers
  logic [57:0] mcand_q, prod_q;
  logic [32:0] mplier_q, dmag_q;
  logic [33:0] rem_q;
  logic        neg_q;
  logic [5:0]  cnt_q;

  // operand select for the current operation
  logic signed [CRV_W-1:0] a_sel, b_sel;
  logic signed [24:0]      a_v;
  logic signed [32:0]      n_v, d_v;
  logic [KNOT_W-1:0]       kn_ref, kn_lo;

  always_comb begin
    a_sel  = '0;
    b_sel  = '0;
    kn_ref = kn_q[1];
    kn_lo  = kn_q[1];
    case (op_q)
      OP_CX2: begin
        a_sel = {pt_q[1][15:0], 8'd0}; b_sel = {pt_q[2][15:0], 8'd0};
        kn_ref = kn_q[3]; kn_lo = kn_q[1];
      end
      OP_CY2: begin
        a_sel = {pt_q[1][31:16], 8'd0}; b_sel = {pt_q[2][31:16], 8'd0};
        kn_ref = kn_q[3]; kn_lo = kn_q[1];
      end
      OP_CX1: begin
        a_sel = {pt_q[0][15:0], 8'd0}; b_sel = {pt_q[1][15:0], 8'd0};
        kn_ref = kn_q[2]; kn_lo = kn_q[0];
      end
      OP_CY1: begin
        a_sel = {pt_q[0][31:16], 8'd0}; b_sel = {pt_q[1][31:16], 8'd0};
        kn_ref = kn_q[2]; kn_lo = kn_q[0];
      end
      OP_PX: begin
        a_sel = cx1_q; b_sel = cx2_q; kn_ref = kn_q[2]; kn_lo = kn_q[1];
      end
      OP_PY: begin
        a_sel = cy1_q; b_sel = cy2_q; kn_ref = kn_q[2]; kn_lo = kn_q[1];
      end
      default: ;
    endcase
    if (op_q == OP_U) begin
      a_v = 25'(s_q);
      n_v = {1'b0, span_q};
      d_v = 33'(dens);
    end else begin
      a_v = {a_sel[CRV_W-1], a_sel} - {b_sel[CRV_W-1], b_sel};
      n_v = {1'b0, kn_ref} - {1'b0, u_q};
      d_v = {1'b0, kn_ref} - {1'b0, kn_lo};
    end
  end

  logic [24:0] a_mag;
  logic [32:0] n_mag, d_mag;
  assign a_mag = a_v[24] ? 25'(-a_v) : 25'(a_v);
  assign n_mag = n_v[32] ? 33'(-n_v) : 33'(n_v);
  assign d_mag = d_v[32] ? 33'(-d_v) : 33'(d_v);

  // divide step and blend result
  logic [33:0] rem_sh;
  logic        q_bit;
  logic [58:0] q_s;
  logic [59:0] sum;
  logic signed [CRV_W-1:0] sat_v;
  assign rem_sh = {rem_q[32:0], prod_q[57]};
  assign q_bit  = (rem_sh >= {1'b0, dmag_q});
  assign q_s    = neg_q ? 59'(-{1'b0, prod_q}) : {1'b0, prod_q};
  assign sum    = {{36{b_sel[CRV_W-1]}}, b_sel} + {q_s[58], q_s};

  always_comb begin
    if (!sum[59] && sum[58:23] != '0) begin
      sat_v = 24'h7FFFFF;
    end else if (sum[59] && sum[58:23] != '1) begin
      sat_v = 24'h800000;
    end else begin
      sat_v = sum[23:0];
    end
  end

  // result commit: zero span passes b through
  logic                    commit;
  logic signed [CRV_W-1:0] commit_v;
  assign commit   = (state_q == S_FIN) ||
                    (state_q == S_SETUP && op_q != OP_U && d_v == '0);
  assign commit_v = (state_q == S_FIN) ? sat_v : b_sel;

  logic out_free, last_pt;
  assign out_free = !out_o.valid || out_o.ready;
  assign last_pt  = (s_q == dens);

  // sequencer next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_acc && in_i.op == CMD_GENERATE && gen_ok) state_d = S_READ;
      S_READ:  if (step_q == 3'd4) state_d = S_CHECK;
      S_CHECK: state_d = (kn_q[2] <= kn_q[1]) ? S_IDLE : S_SETUP;
      S_SETUP: begin
        if (commit) state_d = (op_q == OP_PY) ? S_EMIT : S_SETUP;
        else state_d = S_MUL;
      end
      S_MUL:   if (cnt_q == 6'd32) state_d = S_DIV;
      S_DIV:   if (cnt_q == 6'd57) state_d = S_FIN;
      S_FIN:   state_d = (op_q == OP_PY) ? S_EMIT : S_SETUP;
      S_EMIT:  if (out_free) state_d = last_pt ? S_IDLE : S_SETUP;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    case (state_q)
      S_IDLE: begin
        idx_q  <= in_i.index;
        step_q <= '0;
      end
      S_READ: begin
        step_q <= step_q + 3'd1;
        if (step_q != '0) begin
          kn_q[2'(step_q - 3'd1)] <= knot_rd;
          if (step_q != 3'd4) pt_q[2'(step_q - 3'd1)] <= pt_rd;
        end
      end
      S_CHECK: begin
        span_q <= kn_q[2] - kn_q[1];
        s_q    <= '0;
        op_q   <= OP_U;
      end
      S_SETUP: begin
        mcand_q  <= 58'(a_mag);
        mplier_q <= n_mag;
        dmag_q   <= d_mag;
        prod_q   <= '0;
        neg_q    <= a_v[24] ^ n_v[32] ^ d_v[32];
        cnt_q    <= '0;
      end
      S_MUL: begin
        if (mplier_q[0]) prod_q <= prod_q + mcand_q;
        mcand_q  <= {mcand_q[56:0], 1'b0};
        mplier_q <= {1'b0, mplier_q[32:1]};
        cnt_q    <= (cnt_q == 6'd32) ? '0 : cnt_q + 6'd1;
        rem_q    <= '0;
      end
      S_DIV: begin
        rem_q  <= q_bit ? rem_sh - {1'b0, dmag_q} : rem_sh;
        prod_q <= {prod_q[56:0], q_bit};
        cnt_q  <= cnt_q + 6'd1;
      end
      S_EMIT: begin
        if (out_free) begin
          s_q  <= s_q + DENS_W'(1);
          op_q <= OP_U;
        end
      end
      default: ;
    endcase

    if (state_q == S_FIN && op_q == OP_U) begin
      u_q <= kn_q[1] + prod_q[31:0];
    end
    if (commit) begin
      case (op_q)
        OP_CX2: cx2_q <= commit_v;
        OP_CY2: cy2_q <= commit_v;
        OP_CX1: cx1_q <= commit_v;
        OP_CY1: cy1_q <= commit_v;
        OP_PX:  px_q  <= commit_v;
        OP_PY:  py_q  <= commit_v;
        default: ;
      endcase
      if (op_q != OP_PY) op_q <= op_q + 3'd1;
    end
  end

  // output register
  logic                    ovalid_q, olast_q;
  logic signed [CRV_W-1:0] ox_q, oy_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ovalid_q <= 1'b0;
    end else if (state_q == S_EMIT && out_free) begin
      ovalid_q <= 1'b1;
    end else if (out_o.ready) begin
      ovalid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_EMIT && out_free) begin
      ox_q    <= px_q;
      oy_q    <= py_q;
      olast_q <= last_pt;
    end
  end

  assign out_o.valid   = ovalid_q;
  assign out_o.curve_x = ox_q;
  assign out_o.curve_y = oy_q;
  assign out_o.last    = olast_q;

endmodule

>>> rtl/core/qbpg_ram.sv
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module qbpg_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

>>> rtl/core/qbpg_checker.sv
// Port-level checks for the point generator, bound to its top level.
// Depends on qbpg_pkg for field widths and command codes.
module qbpg_checker import qbpg_pkg::*; (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_ready_i,
  input logic [OP_W-1:0]  in_op_i,
  input logic             out_valid_i,
  input logic             out_ready_i,
  input logic [CRV_W-1:0] out_x_i,
  input logic [CRV_W-1:0] out_y_i,
  input logic             out_last_i
);

  // a stalled word holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_x_i) &&
    $stable(out_y_i) && $stable(out_last_i))
    else $error("output word changed while stalled");

  // only a generate word takes the block busy
  a_busy_cause: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(in_ready_i) |-> $past(in_valid_i && in_op_i == CMD_GENERATE))
    else $error("block went busy without a generate word");

  // loads complete at once
  a_load_fast: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && in_ready_i && in_op_i != CMD_GENERATE |=> in_ready_i)
    else $error("load word left the block busy");

  // points come only from generate work
  a_point_src: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_i) |-> $past(!in_ready_i))
    else $error("point emitted while idle");

endmodule

bind quadratic_bspline_point_generator_unit qbpg_checker u_qbpg_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_i.valid),
  .in_ready_i  (in_i.ready),
  .in_op_i     (in_i.op),
  .out_valid_i (out_o.valid),
  .out_ready_i (out_o.ready),
  .out_x_i     (out_o.curve_x),
  .out_y_i     (out_o.curve_y),
  .out_last_i  (out_o.last)
);

>>> verif/tb_quadratic_bspline_point_generator_unit.sv
// Testbench for the quadratic B-spline point generator.
// Drives command words and config writes, predicts the curve points and checks them in order.
// Depends on qbpg_pkg, qbpg_in_if, qbpg_out_if and the generator top level.
`timescale 1ns / 100ps

module tb_quadratic_bspline_point_generator_unit;
  import qbpg_pkg::*;

  localparam int unsigned NUM_KNOTS  = MAX_KNOTS_DEF;
  localparam logic [OP_W-1:0] CMD_UNUSED = 2'd3;
  localparam int unsigned IDLE_LIMIT = 40000;
  localparam int unsigned DRAIN_WAIT = 1500;
  localparam int unsigned LONG_HOLD  = 3000;
  localparam longint Q24_HI = 64'sd8388607;
  localparam longint Q24_LO = -64'sd8388608;

  typedef struct {
    logic signed [CRV_W-1:0] x;
    logic signed [CRV_W-1:0] y;
    logic                    last;
  } curve_pt_t;

  logic clk_i;
  logic rst_ni;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CFG_DAT_W-1:0] cfg_data;

  qbpg_in_if  cmd_ch ();
  qbpg_out_if pt_ch ();

  quadratic_bspline_point_generator_unit dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_i       (cmd_ch),
    .out_o      (pt_ch),
    .cfg_we_i   (cfg_we),
    .cfg_idx_i  (cfg_idx),
    .cfg_data_i (cfg_data)
  );

  // shadow copy of the stores and registers
  logic [KNOT_W-1:0]      knot_mem [NUM_KNOTS];
  logic signed [PT_W-1:0] ptx_mem  [NUM_KNOTS];
  logic signed [PT_W-1:0] pty_mem  [NUM_KNOTS];
  logic [DENS_W-1:0]      density;
  logic [KCNT_W-1:0]      knot_cnt;

  curve_pt_t pending_pts[$];
  int unsigned err_cnt = 0;
  int unsigned idle_cycles = 0;
  logic hold_tgl = 1'b0;

  // clock
  initial clk_i = 1'b0;
  always begin
    #1 clk_i = 1'b1;
    #1 clk_i = 1'b0;
  end

  // one de Boor blend, saturated to the Q16.8 range
  function automatic longint blend_q(longint a, longint b, longint num, longint den);
    longint r;
    if (den == 0) return b;
    r = b + ((a - b) * num) / den;
    if (r > Q24_HI) return Q24_HI;
    if (r < Q24_LO) return Q24_LO;
    return r;
  endfunction

  // expected points of one generate word
  task automatic predict_interval(input int unsigned i);
    int unsigned eff;
    int unsigned dens;
    longint ka, k0, k1, k2, span, u;
    longint xa, x0, x1, ya, y0, y1;
    longint cx1, cx2, cy1, cy2;
    curve_pt_t pt;
    eff  = (knot_cnt < NUM_KNOTS) ? knot_cnt : NUM_KNOTS;
    dens = (density != 0) ? density : 1;
    if (i < 1 || i + 2 >= eff) return;
    ka = longint'(knot_mem[i-1]);
    k0 = longint'(knot_mem[i]);
    k1 = longint'(knot_mem[i+1]);
    k2 = longint'(knot_mem[i+2]);
    if (k1 <= k0) return;
    span = k1 - k0;
    xa = longint'(ptx_mem[i-1]) * 256;
    x0 = longint'(ptx_mem[i]) * 256;
    x1 = longint'(ptx_mem[i+1]) * 256;
    ya = longint'(pty_mem[i-1]) * 256;
    y0 = longint'(pty_mem[i]) * 256;
    y1 = longint'(pty_mem[i+1]) * 256;
    for (int unsigned s = 0; s <= dens; s++) begin
      u   = k0 + (longint'(s) * span) / longint'(dens);
      cx2 = blend_q(x0, x1, k2 - u, k2 - k0);
      cy2 = blend_q(y0, y1, k2 - u, k2 - k0);
      cx1 = blend_q(xa, x0, k1 - u, k1 - ka);
      cy1 = blend_q(ya, y0, k1 - u, k1 - ka);
      pt.x    = CRV_W'(blend_q(cx1, cx2, k1 - u, span));
      pt.y    = CRV_W'(blend_q(cy1, cy2, k1 - u, span));
      pt.last = (s == dens);
      pending_pts.push_back(pt);
    end
  endtask

  // send one command word, with a random gap ahead of it
  task automatic send_word(input logic [OP_W-1:0] op, input int unsigned idx,
                           input logic [KNOT_W-1:0] kv,
                           input logic signed [PT_W-1:0] px,
                           input logic signed [PT_W-1:0] py);
    int unsigned r;
    int unsigned gap;
    r   = $urandom_range(0, 19);
    gap = (r < 12) ? 0 : (r < 18) ? $urandom_range(1, 3) : $urandom_range(10, 60);
    if (gap != 0) begin
      @(negedge clk_i);
      cmd_ch.valid = 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    cmd_ch.valid      = 1'b1;
    cmd_ch.op         = op;
    cmd_ch.index      = idx[IDX_W-1:0];
    cmd_ch.knot_value = kv;
    cmd_ch.point_x    = px;
    cmd_ch.point_y    = py;
    do @(posedge clk_i); while (!cmd_ch.ready);
    // word accepted at this edge: update the shadow state
    case (op)
      CMD_LOAD_KNOT:  knot_mem[idx] = kv;
      CMD_LOAD_POINT: begin
        ptx_mem[idx] = px;
        pty_mem[idx] = py;
      end
      CMD_GENERATE:   predict_interval(idx);
      default: ;
    endcase
  endtask

  task automatic load_knot(input int unsigned idx, input logic [KNOT_W-1:0] kv);
    send_word(CMD_LOAD_KNOT, idx, kv, '0, '0);
  endtask

  task automatic load_point(input int unsigned idx, input logic signed [PT_W-1:0] px,
                            input logic signed [PT_W-1:0] py);
    send_word(CMD_LOAD_POINT, idx, '0, px, py);
  endtask

  task automatic generate_interval(input int unsigned idx);
    send_word(CMD_GENERATE, idx, $urandom(), PT_W'($urandom()), PT_W'($urandom()));
  endtask

  // wait until every point is in and the sequencer has settled
  task automatic wait_idle();
    @(negedge clk_i);
    cmd_ch.valid = 1'b0;
    while (pending_pts.size() != 0) @(negedge clk_i);
    repeat (30) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input int unsigned val);
    wait_idle();
    cfg_we   = 1'b1;
    cfg_idx  = idx;
    cfg_data = val[CFG_DAT_W-1:0];
    @(negedge clk_i);
    cfg_we   = 1'b0;
    if (idx == REG_DENSITY) density = val[DENS_W-1:0];
    else knot_cnt = val[KCNT_W-1:0];
  endtask

  // knot near its uniform slot, now and then anything at all
  function automatic logic [KNOT_W-1:0] pick_knot(input int unsigned idx);
    if ($urandom_range(0, 9) == 0) return $urandom();
    return (idx << 16) + $urandom_range(0, 16'hFFFF) - 32'h8000;
  endfunction

  task automatic test_fill_stores();
    for (int unsigned k = 0; k < NUM_KNOTS; k++) begin
      load_knot(k, k << 16);
      load_point(k, PT_W'($urandom()), PT_W'($urandom()));
    end
  endtask

  // edge intervals, field extremes, ignored and empty cases
  task automatic test_directed();
    load_point(1, 16'sh7FFF, -16'sh8000);
    load_point(2, -16'sh8000, 16'sh7FFF);
    generate_interval(0);                 // below range
    generate_interval(1);                 // first valid interval
    generate_interval(33);                // last valid with 36 knots
    generate_interval(34);                // one past the range
    generate_interval(63);
    send_word(CMD_UNUSED, 5, '1, '1, '1); // unused op code
    load_knot(11, 10 << 16);              // zero-length interval
    generate_interval(10);
    load_knot(22, 21 << 16);              // knots 20 to 22 equal, so an empty interval
    load_knot(20, 21 << 16);
    generate_interval(20);
    load_knot(30, 32'h0000_0000);         // extreme knots and wide span
    load_knot(31, 32'hFFFF_FFFF);
    load_point(30, 16'sh7FFF, 16'sh7FFF);
    load_point(31, -16'sh8000, -16'sh8000);
    generate_interval(30);
    generate_interval(29);
    load_knot(28, 32'hFFFF_FFFF);         // unordered knots
    generate_interval(28);
  endtask

  task automatic test_config_extremes();
    write_reg(REG_DENSITY, 0);            // density zero acts as one
    write_reg(REG_KNOT_COUNT, 4);
    generate_interval(1);
    generate_interval(2);
    write_reg(REG_DENSITY, 1);
    write_reg(REG_KNOT_COUNT, 127);       // clamps to the store depth
    generate_interval(61);
    generate_interval(62);
    write_reg(REG_DENSITY, 63);
    write_reg(REG_KNOT_COUNT, 64);
    generate_interval(5);
    generate_interval(61);
  endtask

  // mostly well-placed loads and in-range generates
  task automatic test_random(input int unsigned words);
    int unsigned eff;
    int unsigned r;
    int unsigned idx;
    eff = (knot_cnt < NUM_KNOTS) ? knot_cnt : NUM_KNOTS;
    for (int unsigned n = 0; n < words; n++) begin
      r   = $urandom_range(0, 99);
      idx = $urandom_range(0, NUM_KNOTS - 1);
      if (r < 30) load_knot(idx, pick_knot(idx));
      else if (r < 65) load_point(idx, PT_W'($urandom()), PT_W'($urandom()));
      else if (r < 95) begin
        if (eff > 3 && r < 90) idx = $urandom_range(1, eff - 3);
        generate_interval(idx);
      end else send_word(CMD_UNUSED, idx, $urandom(), PT_W'($urandom()), PT_W'($urandom()));
    end
  endtask

  // receiver stalls for a long stretch while generates keep coming
  task automatic test_backpressure();
    write_reg(REG_DENSITY, 4);
    hold_tgl = ~hold_tgl;
    for (int unsigned n = 0; n < 6; n++) generate_interval($urandom_range(1, 33));
  endtask

  // receiver ready; it owns the long hold count
  initial begin
    int unsigned hold_left;
    int unsigned r;
    logic hold_seen;
    hold_left = 0;
    hold_seen = 1'b0;
    pt_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      if (hold_seen != hold_tgl) begin
        hold_seen = hold_tgl;
        hold_left = LONG_HOLD;
      end
      if (hold_left != 0) begin
        hold_left--;
        pt_ch.ready = 1'b0;
      end else begin
        r = $urandom_range(0, 99);
        pt_ch.ready = (r < 70) ? 1'b1 : (r < 97) ? 1'b0 : ($urandom_range(0, 1) == 1);
        if (r >= 98) begin
          pt_ch.ready = 1'b0;
          hold_left = $urandom_range(20, 200);
        end
      end
    end
  end

  // result checker
  always @(posedge clk_i) begin
    curve_pt_t exp_pt;
    if (rst_ni && pt_ch.valid && pt_ch.ready) begin
      if (pending_pts.size() == 0) begin
        $error("point with none expected: x=%0d y=%0d last=%0b",
               pt_ch.curve_x, pt_ch.curve_y, pt_ch.last);
        err_cnt++;
      end else begin
        exp_pt = pending_pts.pop_front();
        if (pt_ch.curve_x !== exp_pt.x) begin
          $error("curve_x: expected %0d, got %0d", exp_pt.x, pt_ch.curve_x);
          err_cnt++;
        end
        if (pt_ch.curve_y !== exp_pt.y) begin
          $error("curve_y: expected %0d, got %0d", exp_pt.y, pt_ch.curve_y);
          err_cnt++;
        end
        if (pt_ch.last !== exp_pt.last) begin
          $error("last: expected %0b, got %0b", exp_pt.last, pt_ch.last);
          err_cnt++;
        end
      end
    end
  end

  // watchdog on cycles with no word moving
  always @(posedge clk_i) begin
    if ((cmd_ch.valid && cmd_ch.ready) || (pt_ch.valid && pt_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= IDLE_LIMIT) begin
      $display("status: fail");
      $finish;
    end
  end

  initial begin
    rst_ni            = 1'b0;
    cfg_we            = 1'b0;
    cfg_idx           = '0;
    cfg_data          = '0;
    cmd_ch.valid      = 1'b0;
    cmd_ch.op         = CMD_LOAD_KNOT;
    cmd_ch.index      = '0;
    cmd_ch.knot_value = '0;
    cmd_ch.point_x    = '0;
    cmd_ch.point_y    = '0;
    density           = DENSITY_RST;
    knot_cnt          = KNOT_COUNT_RST;
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_fill_stores();
    test_directed();
    test_config_extremes();
    write_reg(REG_DENSITY, 3);
    write_reg(REG_KNOT_COUNT, 64);
    test_random(35);
    write_reg(REG_DENSITY, 1);
    write_reg(REG_KNOT_COUNT, 12);
    test_random(30);
    write_reg(REG_DENSITY, 7);
    write_reg(REG_KNOT_COUNT, 100);
    test_random(35);
    write_reg(REG_DENSITY, 2);
    write_reg(REG_KNOT_COUNT, 36);
    test_random(30);
    test_backpressure();
    write_reg(REG_DENSITY, 5);
    write_reg(REG_KNOT_COUNT, 50);
    test_random(33);

    wait_idle();
    repeat (DRAIN_WAIT) @(posedge clk_i);
    if (err_cnt == 0 && pending_pts.size() == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

endmodule

>>> quadratic_bspline_point_generator_unit.f
rtl/core/qbpg_pkg.sv
rtl/core/qbpg_if.sv
rtl/core/qbpg_ram.sv
rtl/core/quadratic_bspline_point_generator_unit.sv
rtl/core/qbpg_checker.sv
verif/tb_quadratic_bspline_point_generator_unit.sv
